// ----- hw/rtl/yee_pkg.sv -----
// ----------------------------------------------------------------------------
// yee_pkg
// Shared constants, codes and types of the 1D Yee field solver block.
// ----------------------------------------------------------------------------
package yee_pkg;

	// Grid geometry and stored field format
	localparam int MAX_CELLS   = 1024;
	localparam int FIELD_WIDTH = 32;
	localparam int CELL_W      = $clog2(MAX_CELLS);
	localparam int NUM_CELLS_W = 11;
	localparam int CNT_W       = (NUM_CELLS_W > CELL_W + 1) ? NUM_CELLS_W : CELL_W + 1;

	// Fixed field widths of the ports
	localparam int COEF_W     = 48;
	localparam int SRC_CELL_W = 10;
	localparam int SRC_W      = 32;
	localparam int VALUE_W    = 32;
	localparam int STATUS_W   = 2;
	localparam int REQ_W      = 2;
	localparam int INDEX_W    = 10;

	// Update datapath widths
	localparam int D_W       = (FIELD_WIDTH + 1 > SRC_W + 1) ? FIELD_WIDTH + 1 : SRC_W + 1;
	localparam int M_W       = D_W;
	localparam int COEF_LO_W = COEF_W / 2;
	localparam int COEF_HI_W = COEF_W - COEF_LO_W;
	localparam int ACC_W     = M_W + COEF_W;
	localparam int FRAC_SH   = 32;
	localparam int Q_W       = ACC_W - FRAC_SH;
	localparam int CAP_SH    = 62;
	localparam int QX_W      = (Q_W > CAP_SH + 1) ? Q_W : CAP_SH + 1;
	localparam int SUB_W     = QX_W + 2;

	// Configuration port
	localparam int ADDR_W    = 6;
	localparam int DATA_W    = 64;
	localparam int REG_IDX_W = 3;
	localparam int REG_LSB   = 3;

	localparam logic [REG_IDX_W-1:0] REG_NUM_CELLS     = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_E_COEF        = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_H_COEF        = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_SOURCE_CELL   = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_SOURCE_ENABLE = 3'd4;

	localparam logic [NUM_CELLS_W-1:0] NUM_CELLS_RST = NUM_CELLS_W'(MAX_CELLS);

	// Request codes
	localparam logic [REQ_W-1:0] REQ_STEP  = 2'd0;
	localparam logic [REQ_W-1:0] REQ_RD_E  = 2'd1;
	localparam logic [REQ_W-1:0] REQ_RD_H  = 2'd2;
	localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd3;

	// Status codes
	localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] STAT_RANGE = 2'd1;
	localparam logic [STATUS_W-1:0] STAT_SAT   = 2'd2;

	typedef logic signed [FIELD_WIDTH-1:0] field_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_RD_ADDR,
		ST_RD_DATA,
		ST_PRIME_RD,
		ST_PRIME_LD,
		ST_C_RD,
		ST_C_LD,
		ST_C_M0,
		ST_C_M1,
		ST_C_RN,
		ST_C_WR
	} state_t;

	typedef enum logic [1:0] {
		PH_E,
		PH_SRC,
		PH_H
	} phase_t;

	// Control of the shared update unit, one strobe per micro step
	typedef struct packed {
		logic load;
		logic mul_lo;
		logic mul_hi;
		logic rnd;
	} upd_ctl_t;

	// Low result bits of a stored value, sign extended where the field is narrow
	function automatic logic signed [VALUE_W-1:0] to_value(input field_t x);
		return VALUE_W'(x);
	endfunction

endpackage

// ----- hw/rtl/yee_ram.sv -----
// ----------------------------------------------------------------------------
// yee_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module yee_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write one entry
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Register the read beat
	always_ff @(posedge clk) begin
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ----- hw/rtl/yee_upd.sv -----
// ----------------------------------------------------------------------------
// yee_upd
// Shared cell update unit: old - round(|a - b| * coef / 2^32) with sign,
// multiplied in two partial products, then saturated to the field range.
// ----------------------------------------------------------------------------
module yee_upd (
	input  logic                              clk,
	input  logic                              arst_n,
	input  yee_pkg::upd_ctl_t                 ctl,
	input  logic signed [yee_pkg::D_W-1:0]    a,
	input  logic signed [yee_pkg::D_W-1:0]    b,
	input  yee_pkg::field_t                   old,
	input  logic [yee_pkg::COEF_W-1:0]        coef,
	output yee_pkg::field_t                   result,
	output logic                              sat
);

	import yee_pkg::*;

	localparam field_t FMAX = {1'b0, {(FIELD_WIDTH-1){1'b1}}};
	localparam field_t FMIN = {1'b1, {(FIELD_WIDTH-1){1'b0}}};
	localparam logic [QX_W-1:0] CAP = QX_W'(1) << CAP_SH;
	localparam logic [ACC_W-1:0] HALF = ACC_W'(1) << (FRAC_SH - 1);

	logic [M_W-1:0]          m_q;
	logic                    neg_q;
	field_t                  old_q;
	logic [ACC_W-1:0]        acc_q;
	logic [QX_W-1:0]         q_q;

	logic signed [D_W-1:0]   diff;
	logic [M_W-1:0]          mag;
	logic [COEF_HI_W-1:0]    coef_part;
	logic [M_W+COEF_HI_W-1:0] prod;
	logic [ACC_W-1:0]        rsum;
	logic [QX_W-1:0]         q_ext;
	logic signed [SUB_W-1:0] term;
	logic signed [SUB_W-1:0] diffr;

	// Form the signed difference and its magnitude
	always_comb begin
		diff = a - b;
		mag  = diff[D_W-1] ? M_W'(-diff) : M_W'(diff);
	end

	// Share one multiplier over the low and high coefficient halves
	always_comb begin
		coef_part = ctl.mul_hi ? coef[COEF_W-1:COEF_LO_W] : COEF_HI_W'(coef[COEF_LO_W-1:0]);
		prod      = (M_W+COEF_HI_W)'(m_q) * (M_W+COEF_HI_W)'(coef_part);
	end

	// Round half away from zero on the magnitude, cap huge terms
	always_comb begin
		rsum  = acc_q + HALF;
		q_ext = QX_W'(rsum[ACC_W-1:FRAC_SH]);
	end

	// Operand, accumulator and rounded term registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			neg_q <= 1'b0;
		end else if (ctl.load) begin
			neg_q <= diff[D_W-1];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			m_q   <= mag;
			old_q <= old;
		end
		if (ctl.mul_lo) begin
			acc_q <= ACC_W'(prod);
		end else if (ctl.mul_hi) begin
			acc_q <= acc_q + (ACC_W'(prod) << COEF_LO_W);
		end
		if (ctl.rnd) begin
			q_q <= (q_ext > CAP) ? CAP : q_ext;
		end
	end

	// Subtract the signed term and clamp to the field range
	always_comb begin
		term  = neg_q ? -$signed({2'b00, q_q}) : $signed({2'b00, q_q});
		diffr = SUB_W'(old_q) - term;
		if (diffr > SUB_W'(FMAX)) begin
			result = FMAX;
			sat    = 1'b1;
		end else if (diffr < SUB_W'(FMIN)) begin
			result = FMIN;
			sat    = 1'b1;
		end else begin
			result = FIELD_WIDTH'(diffr);
			sat    = 1'b0;
		end
	end

endmodule

// ----- hw/rtl/fdtd_1d_leapfrog_step.sv -----
// ----------------------------------------------------------------------------
// fdtd_1d_leapfrog_step
// One-dimensional Yee leapfrog solver holding E and H grids in two RAMs.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low; its one result shows on
// value and status for the single cycle that done is high, and cannot be held
// off. A read item passes an address state and a data state before its result.
// A step walks the grids one cell at a time through a single shared
// multiply-round-saturate unit, each cell in the steps address, load, two
// partial products, round and write back: N-2 cells of E, then N-1 cells of
// H, plus one source cell with the source on. A clear item sweeps all 1024
// entries of both RAMs one entry a cycle. The same sweep runs after reset, with busy high.
// Register writes are taken at any time but must only be made while idle.
module fdtd_1d_leapfrog_step (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  psel,
	input  logic                                  penable,
	input  logic                                  pwrite,
	input  logic [yee_pkg::ADDR_W-1:0]            paddr,
	input  logic [yee_pkg::DATA_W-1:0]            pwdata,
	output logic [yee_pkg::DATA_W-1:0]            prdata,
	output logic                                  pready,
	input  logic                                  start,
	output logic                                  busy,
	input  logic [yee_pkg::REQ_W-1:0]             req_type,
	input  logic signed [yee_pkg::SRC_W-1:0]      source_value,
	input  logic [yee_pkg::INDEX_W-1:0]           cell_index,
	output logic                                  done,
	output logic signed [yee_pkg::VALUE_W-1:0]    value,
	output logic [yee_pkg::STATUS_W-1:0]          status
);

	import yee_pkg::*;

	// Configuration registers
	logic [NUM_CELLS_W-1:0]  num_cells_q;
	logic [COEF_W-1:0]       e_coef_q;
	logic [COEF_W-1:0]       h_coef_q;
	logic [SRC_CELL_W-1:0]   source_cell_q;
	logic                    source_enable_q;

	// Sequencer state
	state_t                  state_q, state_d;
	phase_t                  phase_q, phase_d;
	logic [CELL_W-1:0]       i_q, i_d;
	logic [CELL_W-1:0]       clr_q;
	logic                    clr_item_q;
	logic                    sat_q;
	logic [REQ_W-1:0]        req_q;
	logic [INDEX_W-1:0]      idx_q;
	logic signed [SRC_W-1:0] src_q;
	field_t                  prev_q;

	// Result registers
	logic                    done_q;
	logic signed [VALUE_W-1:0] value_q;
	logic [STATUS_W-1:0]     status_q;

	// Derived control
	logic                    cfg_wr;
	logic [REG_IDX_W-1:0]    reg_idx;
	logic                    accept;
	logic [CNT_W-1:0]        n_eff;
	logic                    src_act;
	logic                    last;
	logic                    rd_ok;
	logic                    clr_end;

	// RAM ports
	logic                    e_we, h_we;
	logic [CELL_W-1:0]       e_waddr, h_waddr, e_raddr, h_raddr;
	field_t                  wdata;
	field_t                  e_rdata, h_rdata;

	// Update unit ports
	upd_ctl_t                ctl;
	logic signed [D_W-1:0]   op_a, op_b;
	field_t                  op_old;
	logic [COEF_W-1:0]       op_coef;
	field_t                  upd_result;
	logic                    upd_sat;

	// Decode a configuration write beat
	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite;
	assign reg_idx = paddr[REG_LSB +: REG_IDX_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_cells_q     <= NUM_CELLS_RST;
			e_coef_q        <= '0;
			h_coef_q        <= '0;
			source_cell_q   <= '0;
			source_enable_q <= 1'b0;
		end else if (cfg_wr) begin
			case (reg_idx)
				REG_NUM_CELLS:     num_cells_q     <= pwdata[NUM_CELLS_W-1:0];
				REG_E_COEF:        e_coef_q        <= pwdata[COEF_W-1:0];
				REG_H_COEF:        h_coef_q        <= pwdata[COEF_W-1:0];
				REG_SOURCE_CELL:   source_cell_q   <= pwdata[SRC_CELL_W-1:0];
				REG_SOURCE_ENABLE: source_enable_q <= pwdata[0];
				default: ;
			endcase
		end
	end

	// Return register contents on a read beat
	always_comb begin
		case (reg_idx)
			REG_NUM_CELLS:     prdata = DATA_W'(num_cells_q);
			REG_E_COEF:        prdata = DATA_W'(e_coef_q);
			REG_H_COEF:        prdata = DATA_W'(h_coef_q);
			REG_SOURCE_CELL:   prdata = DATA_W'(source_cell_q);
			REG_SOURCE_ENABLE: prdata = DATA_W'(source_enable_q);
			default:           prdata = '0;
		endcase
	end

	// Clamp the cell count and qualify the source
	always_comb begin
		if (CNT_W'(num_cells_q) < CNT_W'(2)) begin
			n_eff = CNT_W'(2);
		end else if (CNT_W'(num_cells_q) > CNT_W'(MAX_CELLS)) begin
			n_eff = CNT_W'(MAX_CELLS);
		end else begin
			n_eff = CNT_W'(num_cells_q);
		end
		src_act = source_enable_q && (CNT_W'(source_cell_q) < n_eff);
		last    = (CNT_W'(i_q) == n_eff - CNT_W'(2));
		clr_end = (clr_q == CELL_W'(MAX_CELLS - 1));
		if (req_q == REQ_RD_E) begin
			rd_ok = CNT_W'(idx_q) < n_eff;
		end else begin
			rd_ok = CNT_W'(idx_q) + CNT_W'(1) < n_eff;
		end
	end

	assign accept = start && !busy;

	// Next state of the sequencer
	always_comb begin
		state_d = state_q;
		phase_d = phase_q;
		i_d     = i_q;
		case (state_q)
			ST_CLEAR: begin
				if (clr_end) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (start) begin
					case (req_type)
						REQ_STEP: begin
							if (n_eff > CNT_W'(2)) begin
								phase_d = PH_E;
								state_d = ST_PRIME_RD;
							end else if (src_act) begin
								phase_d = PH_SRC;
								i_d     = CELL_W'(source_cell_q);
								state_d = ST_C_RD;
							end else begin
								phase_d = PH_H;
								state_d = ST_PRIME_RD;
							end
						end
						REQ_RD_E, REQ_RD_H: state_d = ST_RD_ADDR;
						REQ_CLEAR:          state_d = ST_CLEAR;
						default:            state_d = ST_IDLE;
					endcase
				end
			end
			ST_RD_ADDR:  state_d = ST_RD_DATA;
			ST_RD_DATA:  state_d = ST_IDLE;
			ST_PRIME_RD: state_d = ST_PRIME_LD;
			ST_PRIME_LD: begin
				state_d = ST_C_RD;
				i_d     = (phase_q == PH_E) ? CELL_W'(1) : '0;
			end
			ST_C_RD: state_d = ST_C_LD;
			ST_C_LD: state_d = ST_C_M0;
			ST_C_M0: state_d = ST_C_M1;
			ST_C_M1: state_d = ST_C_RN;
			ST_C_RN: state_d = ST_C_WR;
			ST_C_WR: begin
				case (phase_q)
					PH_E: begin
						if (!last) begin
							i_d     = i_q + CELL_W'(1);
							state_d = ST_C_RD;
						end else if (src_act) begin
							phase_d = PH_SRC;
							i_d     = CELL_W'(source_cell_q);
							state_d = ST_C_RD;
						end else begin
							phase_d = PH_H;
							state_d = ST_PRIME_RD;
						end
					end
					PH_SRC: begin
						phase_d = PH_H;
						state_d = ST_PRIME_RD;
					end
					PH_H: begin
						if (last) begin
							state_d = ST_IDLE;
						end else begin
							i_d     = i_q + CELL_W'(1);
							state_d = ST_C_RD;
						end
					end
					default: state_d = ST_IDLE;
				endcase
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Drive RAM ports and update unit strobes
	always_comb begin
		busy    = (state_q != ST_IDLE);
		e_we    = 1'b0;
		h_we    = 1'b0;
		e_waddr = i_q;
		h_waddr = i_q;
		wdata   = upd_result;
		e_raddr = i_q;
		h_raddr = i_q;
		ctl     = '0;
		case (state_q)
			ST_CLEAR: begin
				e_we    = 1'b1;
				h_we    = 1'b1;
				e_waddr = clr_q;
				h_waddr = clr_q;
				wdata   = '0;
			end
			ST_RD_ADDR: begin
				e_raddr = CELL_W'(idx_q);
				h_raddr = CELL_W'(idx_q);
			end
			ST_PRIME_RD: begin
				e_raddr = '0;
				h_raddr = '0;
			end
			ST_C_RD: begin
				e_raddr = (phase_q == PH_H) ? i_q + CELL_W'(1) : i_q;
			end
			ST_C_LD: ctl.load   = 1'b1;
			ST_C_M0: ctl.mul_lo = 1'b1;
			ST_C_M1: ctl.mul_hi = 1'b1;
			ST_C_RN: ctl.rnd    = 1'b1;
			ST_C_WR: begin
				if (phase_q == PH_H) begin
					h_we = 1'b1;
				end else begin
					e_we = 1'b1;
				end
			end
			default: ;
		endcase
	end

	// Select operands for the current phase
	always_comb begin
		case (phase_q)
			PH_SRC: begin
				op_a    = D_W'(src_q);
				op_b    = '0;
				op_old  = e_rdata;
				op_coef = e_coef_q;
			end
			PH_H: begin
				op_a    = D_W'(e_rdata);
				op_b    = D_W'(prev_q);
				op_old  = h_rdata;
				op_coef = h_coef_q;
			end
			default: begin
				op_a    = D_W'(h_rdata);
				op_b    = D_W'(prev_q);
				op_old  = e_rdata;
				op_coef = e_coef_q;
			end
		endcase
	end

	// Advance the sequencer and hold request fields
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			phase_q    <= PH_E;
			i_q        <= '0;
			clr_q      <= '0;
			clr_item_q <= 1'b0;
			sat_q      <= 1'b0;
			req_q      <= REQ_STEP;
			done_q     <= 1'b0;
			status_q   <= STAT_OK;
		end else begin
			state_q <= state_d;
			phase_q <= phase_d;
			i_q     <= i_d;
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + CELL_W'(1);
			end
			if (accept) begin
				req_q <= req_type;
				sat_q <= 1'b0;
				if (req_type == REQ_CLEAR) begin
					clr_q      <= '0;
					clr_item_q <= 1'b1;
				end
			end
			if (state_q == ST_C_WR && upd_sat) begin
				sat_q <= 1'b1;
			end
			// Post one result beat at the end of each item
			done_q <= (state_q == ST_CLEAR && clr_end && clr_item_q)
				|| (state_q == ST_RD_DATA)
				|| (state_q == ST_C_WR && phase_q == PH_H && last);
			if (state_q == ST_CLEAR && clr_end) begin
				clr_item_q <= 1'b0;
				if (clr_item_q) begin
					status_q <= STAT_OK;
				end
			end
			if (state_q == ST_RD_DATA) begin
				status_q <= rd_ok ? STAT_OK : STAT_RANGE;
			end
			if (state_q == ST_C_WR && phase_q == PH_H && last) begin
				status_q <= (sat_q || upd_sat) ? STAT_SAT : STAT_OK;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			idx_q <= cell_index;
			src_q <= source_value;
		end
		if (state_q == ST_PRIME_LD) begin
			prev_q <= (phase_q == PH_E) ? h_rdata : e_rdata;
		end else if (state_q == ST_C_LD && phase_q == PH_E) begin
			prev_q <= h_rdata;
		end else if (state_q == ST_C_LD && phase_q == PH_H) begin
			prev_q <= e_rdata;
		end
		if (state_q == ST_RD_DATA) begin
			if (!rd_ok) begin
				value_q <= '0;
			end else if (req_q == REQ_RD_E) begin
				value_q <= to_value(e_rdata);
			end else begin
				value_q <= to_value(h_rdata);
			end
		end else if (state_q == ST_CLEAR || state_q == ST_C_WR) begin
			value_q <= '0;
		end
	end

	assign done   = done_q;
	assign value  = value_q;
	assign status = status_q;

	yee_ram #(
		.WIDTH (FIELD_WIDTH),
		.DEPTH (MAX_CELLS)
	) u_e_ram (
		.clk   (clk),
		.we    (e_we),
		.waddr (e_waddr),
		.wdata (wdata),
		.raddr (e_raddr),
		.rdata (e_rdata)
	);

	yee_ram #(
		.WIDTH (FIELD_WIDTH),
		.DEPTH (MAX_CELLS)
	) u_h_ram (
		.clk   (clk),
		.we    (h_we),
		.waddr (h_waddr),
		.wdata (wdata),
		.raddr (h_raddr),
		.rdata (h_rdata)
	);

	yee_upd u_upd (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.a      (op_a),
		.b      (op_b),
		.old    (op_old),
		.coef   (op_coef),
		.result (upd_result),
		.sat    (upd_sat)
	);

	// An accepted item keeps the block busy until its result
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted item did not raise busy");

	// A result beat only appears once the sequencer is back to idle
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result beat while busy");

	// Write back never goes past the last cell in use
	a_cell_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_C_WR) |-> (CNT_W'(i_q) < n_eff))
		else $error("cell write beyond grid");

	// The reset sweep posts no result beat
	a_clear_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLEAR && !clr_item_q) |=> !done)
		else $error("result beat from reset sweep");

	// Read results carry only ok or range status
	a_read_status: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RD_DATA) |=> (done && (status == STAT_OK || status == STAT_RANGE)))
		else $error("bad read result");

endmodule
